[rtl/hbl_pkg.sv]
// ----------------------------------------------------------------------------
// hbl_pkg
// Shared constants, codes and types of the host blocklist table.
// ----------------------------------------------------------------------------
package hbl_pkg;

  localparam int ENTRIES  = 16;
  localparam int MAX_NAME = 127;

  localparam int ROW_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int LEN_W = $clog2(MAX_NAME + 1);
  localparam int COL_W = $clog2(MAX_NAME);

  localparam int OP_W   = 2;
  localparam int BYTE_W = 8;
  localparam int ST_W   = 3;
  localparam int SLOT_W = 4;
  localparam int TOT_W  = 5;

  localparam int IN_DATA_W  = BYTE_W;
  localparam int IN_USER_W  = OP_W;
  localparam int OUT_USER_W = ST_W;
  localparam int OUT_DATA_W = ((SLOT_W + TOT_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CHECK  = 2'd2
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_ADDED     = 3'd0,
    ST_FULL      = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_BLOCKED   = 3'd4,
    ST_ALLOWED   = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CMP,
    S_SHIFT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] len_nxt;
    logic             ovf_nxt;
  } name_info_t;

  typedef struct packed {
    logic              en;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [BYTE_W-1:0] data;
  } ent_wr_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } ent_rd_t;

  typedef struct packed {
    logic             en;
    logic [ROW_W-1:0] row;
    logic [LEN_W-1:0] data;
  } len_wr_t;

  typedef struct packed {
    logic              vld;
    status_e           status;
    logic [SLOT_W-1:0] slot;
    logic [TOT_W-1:0]  total;
  } result_t;

endpackage

[rtl/hbl_name_buf.sv]
// ----------------------------------------------------------------------------
// hbl_name_buf
// Collects the bytes of the incoming name into a buffer memory and tracks
// its length and overflow.
// ----------------------------------------------------------------------------
module hbl_name_buf (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       beat_i,
  input  logic                       last_i,
  input  logic [hbl_pkg::BYTE_W-1:0] byte_i,
  input  logic [hbl_pkg::COL_W-1:0]  raddr_i,
  output hbl_pkg::name_info_t        info_o,
  output logic [hbl_pkg::BYTE_W-1:0] rdata_o
);
  import hbl_pkg::*;

  logic [BYTE_W-1:0] mem [2**COL_W];
  logic [LEN_W-1:0]  len_q, len_d;
  logic              ovf_q, ovf_d;
  logic              room;
  logic [BYTE_W-1:0] rdata_q;

  assign room = (len_q < LEN_W'(MAX_NAME));

  always_comb begin
    info_o.len     = len_q;
    info_o.len_nxt = room ? len_q + LEN_W'(1) : len_q;
    info_o.ovf_nxt = ovf_q | ~room;
    len_d = len_q;
    ovf_d = ovf_q;
    if (beat_i) begin
      if (last_i) begin
        len_d = '0;
        ovf_d = 1'b0;
      end else begin
        len_d = info_o.len_nxt;
        ovf_d = info_o.ovf_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      len_q <= len_d;
      ovf_q <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat_i && room) begin
      mem[len_q[COL_W-1:0]] <= byte_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/hbl_entry_store.sv]
// ----------------------------------------------------------------------------
// hbl_entry_store
// Stored names: one byte memory with a row per entry, plus the entry
// length table.
// ----------------------------------------------------------------------------
module hbl_entry_store (
  input  logic                       clk_i,
  input  hbl_pkg::ent_wr_t           wr_i,
  input  hbl_pkg::ent_rd_t           rd_i,
  input  hbl_pkg::len_wr_t           len_wr_i,
  input  logic [hbl_pkg::ROW_W-1:0]  len_rd_row_i,
  output logic [hbl_pkg::BYTE_W-1:0] rdata_o,
  output logic [hbl_pkg::LEN_W-1:0]  len_rdata_o
);
  import hbl_pkg::*;

  logic [BYTE_W-1:0] mem  [ENTRIES * (2**COL_W)];
  logic [LEN_W-1:0]  lens [ENTRIES];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[{wr_i.row, wr_i.col}] <= wr_i.data;
    end
    rdata_q <= mem[{rd_i.row, rd_i.col}];
  end

  always_ff @(posedge clk_i) begin
    if (len_wr_i.en) begin
      lens[len_wr_i.row] <= len_wr_i.data;
    end
  end

  assign rdata_o     = rdata_q;
  assign len_rdata_o = lens[len_rd_row_i];

endmodule

[rtl/hbl_ctrl.sv]
// ----------------------------------------------------------------------------
// hbl_ctrl
// Sequencer: appends on add, walks the table for check and remove, and
// moves later rows down one place after a removal.
// ----------------------------------------------------------------------------
module hbl_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       beat_i,
  input  logic                       last_i,
  input  hbl_pkg::op_e               op_i,
  input  logic [hbl_pkg::BYTE_W-1:0] byte_i,
  input  hbl_pkg::name_info_t        name_i,
  input  logic [hbl_pkg::BYTE_W-1:0] buf_rdata_i,
  input  logic [hbl_pkg::BYTE_W-1:0] ent_rdata_i,
  input  logic [hbl_pkg::LEN_W-1:0]  len_rdata_i,
  input  logic                       out_free_i,
  output logic                       ready_o,
  output logic [hbl_pkg::COL_W-1:0]  buf_raddr_o,
  output hbl_pkg::ent_wr_t           ent_wr_o,
  output hbl_pkg::ent_rd_t           ent_rd_o,
  output hbl_pkg::len_wr_t           len_wr_o,
  output logic [hbl_pkg::ROW_W-1:0]  len_rd_row_o,
  output hbl_pkg::result_t           res_o
);
  import hbl_pkg::*;

  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic [LEN_W-1:0]  nlen_q, nlen_d;
  logic              ovf_q, ovf_d;
  logic [CNT_W-1:0]  ent_q, ent_d;
  logic [CNT_W-1:0]  hit_q, hit_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [LEN_W-1:0]  k_q, k_d;
  logic              rd_vld_q, rd_vld_d;
  logic              rd_last_q, rd_last_d;
  logic [COL_W-1:0]  rd_col_q, rd_col_d;
  status_e           status_q, status_d;
  logic [SLOT_W-1:0] slot_q, slot_d;

  logic [CNT_W-1:0]  ent_nx;
  logic [ROW_W-1:0]  row_cur, row_nx, row_sel;

  assign ent_nx  = ent_q + CNT_W'(1);
  assign row_cur = ent_q[ROW_W-1:0];
  assign row_nx  = ent_nx[ROW_W-1:0];
  assign row_sel = (state_q == S_SHIFT) ? row_nx : row_cur;

  assign buf_raddr_o  = k_q[COL_W-1:0];
  assign ent_rd_o.row = row_sel;
  assign ent_rd_o.col = k_q[COL_W-1:0];
  assign len_rd_row_o = row_sel;

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    nlen_d       = nlen_q;
    ovf_d        = ovf_q;
    ent_d        = ent_q;
    hit_d        = hit_q;
    count_d      = count_q;
    k_d          = k_q;
    rd_vld_d     = 1'b0;
    rd_last_d    = rd_last_q;
    rd_col_d     = rd_col_q;
    status_d     = status_q;
    slot_d       = slot_q;
    ready_o      = 1'b0;
    ent_wr_o     = '0;
    len_wr_o     = '0;
    res_o.vld    = 1'b0;
    res_o.status = status_q;
    res_o.slot   = slot_q;
    res_o.total  = TOT_W'(count_q);

    case (state_q)
      S_IDLE: begin
        ready_o = 1'b1;
        if (beat_i) begin
          // bytes go straight into the next free row
          if ((count_q < CNT_W'(ENTRIES)) && (name_i.len < LEN_W'(MAX_NAME))) begin
            ent_wr_o.en   = 1'b1;
            ent_wr_o.row  = count_q[ROW_W-1:0];
            ent_wr_o.col  = name_i.len[COL_W-1:0];
            ent_wr_o.data = byte_i;
          end
          if (last_i) begin
            case (op_i)
              OP_ADD: begin
                if (count_q < CNT_W'(ENTRIES)) begin
                  len_wr_o.en   = 1'b1;
                  len_wr_o.row  = count_q[ROW_W-1:0];
                  len_wr_o.data = name_i.len_nxt;
                  count_d       = count_q + CNT_W'(1);
                  status_d      = ST_ADDED;
                  slot_d        = SLOT_W'(count_q);
                end else begin
                  status_d = ST_FULL;
                  slot_d   = '0;
                end
                state_d = S_DONE;
              end
              OP_REMOVE, OP_CHECK: begin
                op_d    = op_i;
                nlen_d  = name_i.len_nxt;
                ovf_d   = name_i.ovf_nxt;
                ent_d   = '0;
                state_d = S_SCAN;
              end
              default: ;
            endcase
          end
        end
      end

      S_SCAN: begin
        if (ovf_q || (ent_q >= count_q)) begin
          status_d = (op_q == OP_REMOVE) ? ST_NOT_FOUND : ST_ALLOWED;
          slot_d   = '0;
          state_d  = S_DONE;
        end else if (len_rdata_i == nlen_q) begin
          k_d     = '0;
          state_d = S_CMP;
        end else begin
          ent_d = ent_nx;
        end
      end

      S_CMP: begin
        if (rd_vld_q && (buf_rdata_i != ent_rdata_i)) begin
          ent_d   = ent_nx;
          state_d = S_SCAN;
        end else if (rd_vld_q && rd_last_q) begin
          if (op_q == OP_REMOVE) begin
            hit_d   = ent_q;
            k_d     = '0;
            state_d = S_SHIFT;
          end else begin
            status_d = ST_BLOCKED;
            slot_d   = SLOT_W'(ent_q);
            state_d  = S_DONE;
          end
        end else if (k_q < nlen_q) begin
          rd_vld_d  = 1'b1;
          rd_last_d = (k_q == nlen_q - LEN_W'(1));
          k_d       = k_q + LEN_W'(1);
        end
      end

      S_SHIFT: begin
        if (ent_nx >= count_q) begin
          count_d  = count_q - CNT_W'(1);
          status_d = ST_REMOVED;
          slot_d   = SLOT_W'(hit_q);
          state_d  = S_DONE;
        end else begin
          // copy row ent+1 into row ent, one byte behind the read
          if (rd_vld_q) begin
            ent_wr_o.en   = 1'b1;
            ent_wr_o.row  = row_cur;
            ent_wr_o.col  = rd_col_q;
            ent_wr_o.data = ent_rdata_i;
          end
          if (k_q < len_rdata_i) begin
            rd_vld_d = 1'b1;
            rd_col_d = k_q[COL_W-1:0];
            k_d      = k_q + LEN_W'(1);
          end else if (!rd_vld_q) begin
            len_wr_o.en   = 1'b1;
            len_wr_o.row  = row_cur;
            len_wr_o.data = len_rdata_i;
            ent_d         = ent_nx;
            k_d           = '0;
          end
        end
      end

      S_DONE: begin
        res_o.vld = 1'b1;
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    nlen_q    <= nlen_d;
    ovf_q     <= ovf_d;
    ent_q     <= ent_d;
    hit_q     <= hit_d;
    k_q       <= k_d;
    rd_last_q <= rd_last_d;
    rd_col_q  <= rd_col_d;
    status_q  <= status_d;
    slot_q    <= slot_d;
  end

endmodule

[rtl/host_blocklist_table.sv]
// ----------------------------------------------------------------------------
// host_blocklist_table
// Exact-match table of host names with add, remove and check.
// ----------------------------------------------------------------------------
// Names stream in one byte per beat (opcode in tuser, end of name in tlast);
// the opcode of the last beat decides the action, and that beat alone gives
// a result of status, slot and entry total. Bytes are taken one per cycle
// while the block is idle, also while an earlier result still waits on the
// output. An add, also one to a full table, is decided at the last byte
// without a walk. Check and remove walk the table with one read port on the
// name memory: an entry whose length differs is passed over, and an entry
// of equal length has its bytes compared through a registered read, which
// stops early when a byte differs; the walk ends when nothing matches. A
// removal then moves every later row down one place, byte by byte, and
// writes its length. A result waits in the done state while the output
// register still holds an unaccepted beat, and then passes to that register.
// ----------------------------------------------------------------------------
module host_blocklist_table (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [hbl_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,  // name_byte
  input  logic [hbl_pkg::IN_USER_W-1:0]  s_axis_tuser_i,  // opcode
  input  logic                           s_axis_tlast_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [hbl_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,  // slot, entry_total, zero pad
  output logic [hbl_pkg::OUT_USER_W-1:0] m_axis_tuser_o   // status
);
  import hbl_pkg::*;

  logic              beat;
  logic              out_free;
  name_info_t        name_info;
  logic [BYTE_W-1:0] buf_rdata;
  logic [BYTE_W-1:0] ent_rdata;
  logic [LEN_W-1:0]  len_rdata;
  logic [COL_W-1:0]  buf_raddr;
  ent_wr_t           ent_wr;
  ent_rd_t           ent_rd;
  len_wr_t           len_wr;
  logic [ROW_W-1:0]  len_rd_row;
  result_t           res;

  logic                  m_vld_q, m_vld_d;
  logic [OUT_DATA_W-1:0] m_data_q;
  logic [OUT_USER_W-1:0] m_user_q;

  assign beat     = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free = ~m_vld_q | m_axis_tready_i;

  hbl_name_buf u_name_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .beat_i  (beat),
    .last_i  (s_axis_tlast_i),
    .byte_i  (s_axis_tdata_i),
    .raddr_i (buf_raddr),
    .info_o  (name_info),
    .rdata_o (buf_rdata)
  );

  hbl_entry_store u_entry_store (
    .clk_i        (clk_i),
    .wr_i         (ent_wr),
    .rd_i         (ent_rd),
    .len_wr_i     (len_wr),
    .len_rd_row_i (len_rd_row),
    .rdata_o      (ent_rdata),
    .len_rdata_o  (len_rdata)
  );

  hbl_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_i       (beat),
    .last_i       (s_axis_tlast_i),
    .op_i         (op_e'(s_axis_tuser_i)),
    .byte_i       (s_axis_tdata_i),
    .name_i       (name_info),
    .buf_rdata_i  (buf_rdata),
    .ent_rdata_i  (ent_rdata),
    .len_rdata_i  (len_rdata),
    .out_free_i   (out_free),
    .ready_o      (s_axis_tready_o),
    .buf_raddr_o  (buf_raddr),
    .ent_wr_o     (ent_wr),
    .ent_rd_o     (ent_rd),
    .len_wr_o     (len_wr),
    .len_rd_row_o (len_rd_row),
    .res_o        (res)
  );

  assign m_vld_d = (res.vld & out_free) | (m_vld_q & ~m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else begin
      m_vld_q <= m_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.vld && out_free) begin
      m_data_q <= OUT_DATA_W'({res.total, res.slot});
      m_user_q <= res.status;
    end
  end

  assign m_axis_tvalid_o = m_vld_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  a_added_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o == ST_ADDED)) |->
      (TOT_W'(m_axis_tdata_o[SLOT_W-1:0]) ==
       m_axis_tdata_o[SLOT_W+TOT_W-1:SLOT_W] - TOT_W'(1)))
    else $error("added slot does not match entry total");

  a_full_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o == ST_FULL)) |->
      (m_axis_tdata_o[SLOT_W+TOT_W-1:SLOT_W] == TOT_W'(ENTRIES)))
    else $error("full reported below capacity");

  a_removed_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o == ST_REMOVED)) |->
      (TOT_W'(m_axis_tdata_o[SLOT_W-1:0]) <= m_axis_tdata_o[SLOT_W+TOT_W-1:SLOT_W]))
    else $error("removed slot beyond table");

  a_no_beat_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && res.vld))
    else $error("input taken while a result is pending");

endmodule
